/* rtl/core/lrpg_pkg.sv */
// Shared types, codes and constants of the LED ring pattern generator.
`default_nettype none
package lrpg_pkg;

    // Default ring sizes and eye count
    localparam int LRPG_OUTER_DEF  = 24;
    localparam int LRPG_MIDDLE_DEF = 16;
    localparam int LRPG_INNER_DEF  = 8;
    localparam int LRPG_EYES_DEF   = 2;

    // Ring and pixel geometry
    localparam int RING_COUNT = 3;
    localparam int PIXEL_W    = 5;
    localparam int PIXEL_SPAN = 1 << PIXEL_W;
    localparam int IDX_W      = 7;
    localparam int HUE_W      = 8;
    localparam int HUE_SPAN   = 256;
    localparam logic [HUE_W-1:0] HUE_HALF = 8'd128;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int STEP_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Pattern codes
    typedef enum logic [2:0] {
        PAT_CHASER    = 3'd0,
        PAT_CASCADE   = 3'd1,
        PAT_RAINBOW   = 3'd2,
        PAT_SPLIT     = 3'd3,
        PAT_ALTERNATE = 3'd4
    } t_pattern;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN     = 3'd0,
        CFG_BASE_HUE    = 3'd1,
        CFG_DIRECTIONS  = 3'd2,
        CFG_OPPOSE      = 3'd3,
        CFG_WIDTHS      = 3'd4,
        CFG_CASCADE_MS  = 3'd5,
        CFG_SPLIT_MS    = 3'd6,
        CFG_ALTERNATE_MS = 3'd7
    } t_cfg_reg;

    // Request codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register reset values
    localparam logic [2:0]        RST_PATTERN    = 3'd0;
    localparam logic [HUE_W-1:0]  RST_BASE_HUE   = 8'd100;
    localparam logic [2:0]        RST_DIRECTIONS = 3'd7;
    localparam logic              RST_OPPOSE     = 1'b0;
    localparam logic [14:0]       RST_WIDTHS     = 15'd6245;
    localparam logic [STEP_W-1:0] RST_CASCADE_MS = 16'd300;
    localparam logic [STEP_W-1:0] RST_SPLIT_MS   = 16'd400;
    localparam logic [STEP_W-1:0] RST_ALT_MS     = 16'd100;

    // Configuration seen by the back end
    typedef struct packed {
        logic [2:0]        pattern;
        logic [HUE_W-1:0]  base_hue;
        logic [2:0]        directions;
        logic              oppose;
        logic [14:0]       widths;
        logic [STEP_W-1:0] cascade_ms;
        logic [STEP_W-1:0] split_ms;
        logic [STEP_W-1:0] alternate_ms;
    } t_cfg;

    // Classified item, front to back
    typedef struct packed {
        logic               is_query;
        logic [TIME_W-1:0]  now_ms;
        logic               eye;
        logic [1:0]         ring;
        logic [PIXEL_W-1:0] pixel;
        logic               in_range;
        logic [IDX_W-1:0]   led_index;
        logic [PIXEL_W-1:0] ring_len;
        logic [HUE_W-1:0]   rain_hue;
        logic               split_top;
    } t_item;

endpackage
`default_nettype wire

/* rtl/core/lrpg_front.sv */
// Front end: accepts requests and precomputes ring geometry and lookups.
`default_nettype none
module lrpg_front #(
    parameter int OUTER_RING_LEDS  = lrpg_pkg::LRPG_OUTER_DEF,
    parameter int MIDDLE_RING_LEDS = lrpg_pkg::LRPG_MIDDLE_DEF,
    parameter int INNER_RING_LEDS  = lrpg_pkg::LRPG_INNER_DEF,
    parameter int EYE_COUNT        = lrpg_pkg::LRPG_EYES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_req_type,
    input  wire logic [31:0]            i_now_ms,
    input  wire logic                   i_eye,
    input  wire logic [1:0]             i_ring,
    input  wire logic [4:0]             i_pixel,
    output logic                        o_item_valid,
    input  wire logic                   i_item_ready,
    output lrpg_pkg::t_item             o_item
);
    import lrpg_pkg::*;

    localparam logic [PIXEL_W-1:0] LEN0 = PIXEL_W'(OUTER_RING_LEDS);
    localparam logic [PIXEL_W-1:0] LEN1 = PIXEL_W'(MIDDLE_RING_LEDS);
    localparam logic [PIXEL_W-1:0] LEN2 = PIXEL_W'(INNER_RING_LEDS);
    localparam logic [IDX_W-1:0] EYE_STRIDE =
        IDX_W'(OUTER_RING_LEDS + MIDDLE_RING_LEDS + INNER_RING_LEDS);
    localparam logic [IDX_W-1:0] OFF1 = IDX_W'(OUTER_RING_LEDS);
    localparam logic [IDX_W-1:0] OFF2 = IDX_W'(OUTER_RING_LEDS + MIDDLE_RING_LEDS);

    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic [PIXEL_W-1:0] w_len;
    logic [IDX_W-1:0]   w_off;
    logic               w_ring_ok;
    logic [HUE_W-1:0]   w_hue_tab [RING_COUNT][PIXEL_SPAN];
    logic [PIXEL_W:0]   w_split_sum;
    logic [PIXEL_W:0]   w_split_mod;

    // Rainbow hue tables, one per ring, fixed at elaboration
    for (genvar p = 0; p < PIXEL_SPAN; p++) begin : g_hue
        localparam logic [HUE_W-1:0] H0 = HUE_W'((p * HUE_SPAN) / OUTER_RING_LEDS);
        localparam logic [HUE_W-1:0] H1 = HUE_W'((p * HUE_SPAN) / MIDDLE_RING_LEDS);
        localparam logic [HUE_W-1:0] H2 = HUE_W'((p * HUE_SPAN) / INNER_RING_LEDS);
        assign w_hue_tab[0][p] = H0;
        assign w_hue_tab[1][p] = H1;
        assign w_hue_tab[2][p] = H2;
    end

    // Ring geometry select
    always_comb begin
        w_ring_ok = 1'b1;
        case (i_ring)
            2'd0: begin
                w_len = LEN0;
                w_off = '0;
            end
            2'd1: begin
                w_len = LEN1;
                w_off = OFF1;
            end
            2'd2: begin
                w_len = LEN2;
                w_off = OFF2;
            end
            default: begin
                w_len     = LEN0;
                w_off     = '0;
                w_ring_ok = 1'b0;
            end
        endcase
    end

    // Classification of the incoming item
    always_comb begin
        w_split_sum = {1'b0, i_pixel} + {3'b0, w_len[PIXEL_W-1:2]};
        w_split_mod = (w_split_sum >= {1'b0, w_len}) ? w_split_sum - {1'b0, w_len}
                                                    : w_split_sum;
        n_item.is_query  = (i_req_type == REQ_QUERY);
        n_item.now_ms    = i_now_ms;
        n_item.eye       = i_eye;
        n_item.ring      = i_ring;
        n_item.pixel     = i_pixel;
        n_item.in_range  = w_ring_ok && (i_pixel < w_len) && (32'(i_eye) < EYE_COUNT);
        n_item.led_index = w_ring_ok ?
            ((i_eye ? EYE_STRIDE : '0) + w_off + IDX_W'(i_pixel)) : '0;
        n_item.ring_len  = w_len;
        n_item.rain_hue  = w_ring_ok ? w_hue_tab[i_ring][i_pixel] : '0;
        n_item.split_top = (w_split_mod < {2'b0, w_len[PIXEL_W-1:1]});
    end

    assign o_in_ready = !r_valid || i_item_ready;

    // Front pipeline register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule
`default_nettype wire

/* rtl/core/lrpg_queue.sv */
// Short FIFO that decouples the front end from the back end.
`default_nettype none
module lrpg_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  lrpg_pkg::t_item     i_push_item,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output lrpg_pkg::t_item     o_pop_item
);
    import lrpg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lrpg_back.sv */
// Back end: pattern state, tick handling and pixel evaluation.
`default_nettype none
module lrpg_back #(
    parameter int OUTER_RING_LEDS  = lrpg_pkg::LRPG_OUTER_DEF,
    parameter int MIDDLE_RING_LEDS = lrpg_pkg::LRPG_MIDDLE_DEF,
    parameter int INNER_RING_LEDS  = lrpg_pkg::LRPG_INNER_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  lrpg_pkg::t_cfg      i_cfg,
    input  wire logic           i_item_valid,
    output logic                o_item_ready,
    input  lrpg_pkg::t_item     i_item,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [6:0]          o_led_index,
    output logic                o_lit,
    output logic [7:0]          o_pixel_hue
);
    import lrpg_pkg::*;

    localparam logic [PIXEL_W-1:0] LEN [RING_COUNT] = '{
        PIXEL_W'(OUTER_RING_LEDS), PIXEL_W'(MIDDLE_RING_LEDS), PIXEL_W'(INNER_RING_LEDS)
    };

    logic [PIXEL_W-1:0] r_chase_pos [RING_COUNT];
    logic [PIXEL_W-1:0] r_rain_pos  [RING_COUNT];
    logic [1:0]         r_cascade_phase;
    logic [TIME_W-1:0]  r_cascade_last;
    logic               r_split_phase;
    logic [TIME_W-1:0]  r_split_last;
    logic               r_alt_phase;
    logic [TIME_W-1:0]  r_alt_last;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_led_index;
    logic               r_lit;
    logic [HUE_W-1:0]   r_hue;

    logic               w_pop;
    logic               w_tick;
    logic               w_query;
    logic [PIXEL_W-1:0] w_pos;
    logic [PIXEL_W-1:0] w_width;
    logic               w_fwd;
    logic               w_dir_bit;
    logic [PIXEL_W-1:0] w_len;
    logic [PIXEL_W-1:0] w_head;
    logic [PIXEL_W:0]   w_dsum;
    logic [PIXEL_W:0]   w_delta;
    logic [PIXEL_W:0]   w_osum;
    logic [PIXEL_W:0]   w_odelta;
    logic               w_chase_lit;
    logic               w_lit;
    logic [HUE_W-1:0]   w_hue;
    logic               w_cascade_due;
    logic               w_split_due;
    logic               w_alt_due;

    // Pop from the queue when the head is a tick or the output slot frees up
    assign o_item_ready = !i_item.is_query || !r_out_valid || i_out_ready;
    assign w_pop        = i_item_valid && o_item_ready;
    assign w_tick       = w_pop && !i_item.is_query;
    assign w_query      = w_pop && i_item.is_query;

    // Per-ring selects for the chaser rule
    always_comb begin
        case (i_item.ring)
            2'd0: begin
                w_width   = i_cfg.widths[4:0];
                w_dir_bit = i_cfg.directions[0];
                w_pos     = (i_cfg.pattern == PAT_RAINBOW) ? r_rain_pos[0] : r_chase_pos[0];
            end
            2'd1: begin
                w_width   = i_cfg.widths[9:5];
                w_dir_bit = i_cfg.directions[1];
                w_pos     = (i_cfg.pattern == PAT_RAINBOW) ? r_rain_pos[1] : r_chase_pos[1];
            end
            2'd2: begin
                w_width   = i_cfg.widths[14:10];
                w_dir_bit = i_cfg.directions[2];
                w_pos     = (i_cfg.pattern == PAT_RAINBOW) ? r_rain_pos[2] : r_chase_pos[2];
            end
            default: begin
                w_width   = '0;
                w_dir_bit = 1'b0;
                w_pos     = '0;
            end
        endcase
    end

    // Chaser: head position, distance behind the head, and the opposite head
    always_comb begin
        w_len    = i_item.ring_len;
        w_fwd    = w_dir_bit ^ (i_cfg.oppose && !i_item.eye);
        w_head   = (w_fwd || w_pos == '0) ? w_pos : w_len - w_pos;
        w_dsum   = {1'b0, i_item.pixel} + {1'b0, w_len} - {1'b0, w_head};
        w_delta  = (w_dsum >= {1'b0, w_len}) ? w_dsum - {1'b0, w_len} : w_dsum;
        w_osum   = w_delta + {2'b0, w_len[PIXEL_W-1:1]};
        w_odelta = (w_osum >= {1'b0, w_len}) ? w_osum - {1'b0, w_len} : w_osum;
        w_chase_lit = (w_delta < {1'b0, w_width}) ||
                      ((i_item.ring != 2'd2) && (w_odelta < {1'b0, w_width}));
    end

    // Pixel evaluation per pattern
    always_comb begin
        w_lit = 1'b0;
        w_hue = i_cfg.base_hue;
        case (i_cfg.pattern)
            PAT_CHASER: begin
                w_lit = w_chase_lit;
            end
            PAT_RAINBOW: begin
                w_lit = w_chase_lit;
                w_hue = i_item.rain_hue;
            end
            PAT_CASCADE: begin
                w_lit = (r_cascade_phase == i_item.ring);
            end
            PAT_SPLIT: begin
                w_lit = r_split_phase ? !i_item.split_top : i_item.split_top;
            end
            PAT_ALTERNATE: begin
                w_lit = 1'b1;
                w_hue = (i_item.pixel[0] ^ r_alt_phase) ? i_cfg.base_hue + HUE_HALF
                                                        : i_cfg.base_hue;
            end
            default: begin
                w_lit = 1'b0;
            end
        endcase
        w_lit = w_lit && i_item.in_range;
        if (!w_lit) begin
            w_hue = '0;
        end
    end

    // Timed step checks, wraparound difference against the interval
    assign w_cascade_due = (i_item.now_ms - r_cascade_last) > {16'b0, i_cfg.cascade_ms};
    assign w_split_due   = (i_item.now_ms - r_split_last) > {16'b0, i_cfg.split_ms};
    assign w_alt_due     = (i_item.now_ms - r_alt_last) > {16'b0, i_cfg.alternate_ms};

    // Pattern state, advanced by frame ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RING_COUNT; r++) begin
                r_chase_pos[r] <= '0;
                r_rain_pos[r]  <= '0;
            end
            r_cascade_phase <= '0;
            r_cascade_last  <= '0;
            r_split_phase   <= 1'b0;
            r_split_last    <= '0;
            r_alt_phase     <= 1'b0;
            r_alt_last      <= '0;
        end else if (w_tick) begin
            case (i_cfg.pattern)
                PAT_CHASER: begin
                    for (int r = 0; r < RING_COUNT; r++) begin
                        r_chase_pos[r] <= (r_chase_pos[r] + 1'b1 == LEN[r]) ? '0
                                          : r_chase_pos[r] + 1'b1;
                    end
                end
                PAT_RAINBOW: begin
                    for (int r = 0; r < RING_COUNT; r++) begin
                        r_rain_pos[r] <= (r_rain_pos[r] + 1'b1 == LEN[r]) ? '0
                                         : r_rain_pos[r] + 1'b1;
                    end
                end
                PAT_CASCADE: begin
                    if (w_cascade_due) begin
                        r_cascade_last  <= i_item.now_ms;
                        r_cascade_phase <= (r_cascade_phase == 2'd2) ? 2'd0
                                           : r_cascade_phase + 1'b1;
                    end
                end
                PAT_SPLIT: begin
                    if (w_split_due) begin
                        r_split_last  <= i_item.now_ms;
                        r_split_phase <= !r_split_phase;
                    end
                end
                PAT_ALTERNATE: begin
                    if (w_alt_due) begin
                        r_alt_last  <= i_item.now_ms;
                        r_alt_phase <= !r_alt_phase;
                    end
                end
                default: begin
                    r_split_phase <= r_split_phase;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_query) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_led_index <= i_item.led_index;
            r_lit       <= w_lit;
            r_hue       <= w_hue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_led_index;
    assign o_lit       = r_lit;
    assign o_pixel_hue = r_hue;

endmodule
`default_nettype wire

/* rtl/core/led_ring_pattern_generator.sv */
// LED ring pattern generator: two eyes of three rings, animation and pixel lookup.
//
// Usage: requests enter on the input channel (i_in_valid / o_in_ready). A frame
// tick (req_type 0) advances the selected pattern using i_now_ms and gives no
// result. A pixel query (req_type 1) gives one transfer on the output channel
// (o_out_valid / i_out_ready) with the LED chain index, lit flag and hue.
// Items are handled strictly in order, so a query sees every earlier tick.
// Throughput: one item per cycle while the receiver takes results; the front
// register, a two-entry queue and the output register keep the input open
// while a result waits.
// When the receiver stalls, the output register holds, the queue fills and
// then the input channel deasserts ready; ticks keep draining meanwhile only
// up to the first blocked query.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); the
// user writes it only while the block is idle, which the block does not enforce;
// values are masked to register width. Reset (synchronous, active low) clears all
// pattern state and restores the register defaults; no clearing pass is needed.
`default_nettype none
module led_ring_pattern_generator #(
    parameter int OUTER_RING_LEDS  = lrpg_pkg::LRPG_OUTER_DEF,
    parameter int MIDDLE_RING_LEDS = lrpg_pkg::LRPG_MIDDLE_DEF,
    parameter int INNER_RING_LEDS  = lrpg_pkg::LRPG_INNER_DEF,
    parameter int EYE_COUNT        = lrpg_pkg::LRPG_EYES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_eye,
    input  wire logic [1:0]  i_ring,
    input  wire logic [4:0]  i_pixel,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [6:0]       o_led_index,
    output logic             o_lit,
    output logic [7:0]       o_pixel_hue
);
    import lrpg_pkg::*;

    t_cfg   r_cfg;
    logic   w_f_valid;
    logic   w_f_ready;
    t_item  w_f_item;
    logic   w_q_valid;
    logic   w_q_ready;
    t_item  w_q_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern      <= RST_PATTERN;
            r_cfg.base_hue     <= RST_BASE_HUE;
            r_cfg.directions   <= RST_DIRECTIONS;
            r_cfg.oppose       <= RST_OPPOSE;
            r_cfg.widths       <= RST_WIDTHS;
            r_cfg.cascade_ms   <= RST_CASCADE_MS;
            r_cfg.split_ms     <= RST_SPLIT_MS;
            r_cfg.alternate_ms <= RST_ALT_MS;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN:      r_cfg.pattern      <= i_cfg_data[2:0];
                CFG_BASE_HUE:     r_cfg.base_hue     <= i_cfg_data[7:0];
                CFG_DIRECTIONS:   r_cfg.directions   <= i_cfg_data[2:0];
                CFG_OPPOSE:       r_cfg.oppose       <= i_cfg_data[0];
                CFG_WIDTHS:       r_cfg.widths       <= i_cfg_data[14:0];
                CFG_CASCADE_MS:   r_cfg.cascade_ms   <= i_cfg_data;
                CFG_SPLIT_MS:     r_cfg.split_ms     <= i_cfg_data;
                CFG_ALTERNATE_MS: r_cfg.alternate_ms <= i_cfg_data;
                default:          r_cfg.pattern      <= r_cfg.pattern;
            endcase
        end
    end

    lrpg_front #(
        .OUTER_RING_LEDS  (OUTER_RING_LEDS),
        .MIDDLE_RING_LEDS (MIDDLE_RING_LEDS),
        .INNER_RING_LEDS  (INNER_RING_LEDS),
        .EYE_COUNT        (EYE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_now_ms     (i_now_ms),
        .i_eye        (i_eye),
        .i_ring       (i_ring),
        .i_pixel      (i_pixel),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_f_ready),
        .o_item       (w_f_item)
    );

    lrpg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_item  (w_f_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    lrpg_back #(
        .OUTER_RING_LEDS  (OUTER_RING_LEDS),
        .MIDDLE_RING_LEDS (MIDDLE_RING_LEDS),
        .INNER_RING_LEDS  (INNER_RING_LEDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_led_index  (o_led_index),
        .o_lit        (o_lit),
        .o_pixel_hue  (o_pixel_hue)
    );

endmodule
`default_nettype wire
